@@ hdl/cramer_linear_solver_core_macros.svh @@
// Assertion helpers for the checker file.
`ifndef CRAMER_LINEAR_SOLVER_CORE_MACROS_SVH
`define CRAMER_LINEAR_SOLVER_CORE_MACROS_SVH

// Clocked assertion, muted while reset is held
`define CLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define CLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/cls_pkg.sv @@
`timescale 1ns / 1ps
package cls_pkg;

  // Field widths
  localparam int CW    = 16;           // coefficient / rhs
  localparam int SW    = 32;           // solution, Q15.16
  localparam int OF    = 16;           // solution fraction bits
  localparam int DW    = 49;           // determinant and numerators
  localparam int MAGW  = DW - 1;       // magnitude of a determinant
  localparam int PW    = 2 * CW;       // 2x2 product
  localparam int MW    = PW + 1;       // 2x2 minor
  localparam int NCOEF = 9;
  localparam int NRHS  = 3;
  localparam int NMIN  = 9;

  // Stream layout
  localparam int IN_TDATA_W  = (NCOEF + NRHS) * CW;
  localparam int OUT_BITS    = DW + 3 * SW;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;
  localparam int DET_LSB     = 0;
  localparam int SOLX_LSB    = DW;
  localparam int SOLY_LSB    = DW + SW;
  localparam int SOLZ_LSB    = DW + 2 * SW;
  localparam int USER_SING   = 0;
  localparam int USER_SAT    = 1;

  // Size register codes
  localparam logic [1:0] SIZE_2X2   = 2'd2;
  localparam logic [1:0] SIZE_RESET = 2'd3;

  // Solution limits
  localparam logic [SW-1:0] SOL_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SOL_MIN = {1'b1, {(SW-1){1'b0}}};

  // Pipeline layout
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = SW / DIV_BITS;
  localparam int ST_IN      = 0;
  localparam int ST_PROD    = 1;
  localparam int ST_MINOR   = 2;
  localparam int ST_TERM    = 3;
  localparam int ST_SUM     = 4;
  localparam int ST_PREP    = 5;
  localparam int ST_DIV0    = 6;
  localparam int NSTG       = ST_DIV0 + DIV_STAGES;

  // Coefficient pairs of the 2x2 minors: minor k = p[2k] - p[2k+1]
  localparam int PROD_A [2*NMIN] = '{4, 5, 1, 2, 1, 2, 3, 5, 0, 2, 0, 2, 3, 4, 0, 1, 0, 1};
  localparam int PROD_B [2*NMIN] = '{8, 7, 8, 7, 5, 4, 8, 6, 8, 6, 5, 3, 7, 6, 7, 6, 4, 3};

  typedef logic signed [CW-1:0] coef_t;

  // One quotient in flight through the divider
  typedef struct packed {
    logic [MAGW-1:0] rem;
    logic [MAGW-1:0] den;
    logic [SW-1:0]   quo;
    logic [SW-1:0]   low;   // dividend bits not yet shifted in, MSB first
    logic            neg;
    logic            big;   // quotient known to exceed SW bits
  } div_lane_t;

  // One restoring division step
  function automatic div_lane_t div_step(div_lane_t l);
    logic [MAGW:0] trial;
    div_lane_t     r;
    r     = l;
    trial = {l.rem, l.low[SW-1]};
    r.low = {l.low[SW-2:0], 1'b0};
    if (trial >= {1'b0, l.den}) begin
      r.rem = MAGW'(trial - {1'b0, l.den});
      r.quo = {l.quo[SW-2:0], 1'b1};
    end else begin
      r.rem = trial[MAGW-1:0];
      r.quo = {l.quo[SW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ hdl/cramer_linear_solver_core.sv @@
`timescale 1ns / 1ps
// Cramer's-rule solver for one 2x2 or 3x3 system per transaction.
// Input stream: tdata carries a_r0c0..a_r2c2 then rhs_0..rhs_2, 16-bit
// signed Q7.8 each, lowest field in the lowest bits.
// Output stream: tdata carries determinant (49b), sol_x, sol_y, sol_z
// (Q15.16, saturated); tuser carries singular (bit 0), saturated (bit 1).
// Config channel: cfg_data_i writes system_size (2 = 2x2, else 3x3).
// Write it only while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled.
// Pipeline: an input register, 5 arithmetic stages (minor products,
// minors, cofactor products, sums, magnitude prep), 16 divider stages
// retiring 2 quotient bits each, and the output register.
// Reset clears all stage valids, empties the output and sets size to 3.
// A receiver stall holds the output register; bubbles inside the pipe
// still collapse, so input stays ready until every stage is full.
module cramer_linear_solver_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2,
  // rhs_0, rhs_1, rhs_2
  input  logic [cls_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // determinant, sol_x, sol_y, sol_z, zero pad
  output logic [cls_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // singular, saturated
  output logic [cls_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_data_i
);
  import cls_pkg::*;

  logic [1:0] size_q;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   rdy;
  logic            out_vld_q;

  coef_t a_d [NCOEF];
  coef_t b_d [NRHS];
  coef_t a_q [NCOEF];
  coef_t b_q [NRHS];

  logic signed [PW-1:0] prod_q [2*NMIN];
  coef_t col_s1_q [NRHS];
  coef_t b_s1_q   [NRHS];

  logic signed [MW-1:0] mn_q [NMIN];
  coef_t col_s2_q [NRHS];
  coef_t b_s2_q   [NRHS];

  logic signed [DW-1:0] term_q [4*NRHS];
  logic signed [DW-1:0] sum_q  [4];

  div_lane_t       prep_q [NRHS];
  logic [DW-1:0]   det_p_q;
  logic            sing_p_q;

  div_lane_t       div_src [DIV_STAGES][NRHS];
  div_lane_t       div_q   [DIV_STAGES][NRHS];
  logic [DW-1:0]   det_v_q  [DIV_STAGES];
  logic            sing_v_q [DIV_STAGES];

  logic [SW-1:0]   sol_d [NRHS];
  logic [NRHS-1:0] sat_d;
  logic [SW-1:0]   sol_q [NRHS];
  logic [DW-1:0]   det_o_q;
  logic            sing_o_q;
  logic            sat_o_q;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // Ready ripple: a stage loads when it is empty or its successor moves
  assign rdy[NSTG] = !out_vld_q || m_axis_tready_i;
  for (genvar g = 0; g < NSTG; g++) begin : g_rdy
    assign rdy[g] = !vld_q[g] || rdy[g+1];
  end
  assign s_axis_tready_o = rdy[ST_IN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy[ST_IN]) vld_q[ST_IN] <= s_axis_tvalid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i-1];
      end
      if (rdy[NSTG]) out_vld_q <= vld_q[NSTG-1];
    end
  end

  // Unpack; a 2x2 system is embedded as a 3x3 with a unit corner
  always_comb begin
    for (int i = 0; i < NCOEF; i++) a_d[i] = s_axis_tdata_i[i*CW +: CW];
    for (int i = 0; i < NRHS; i++)  b_d[i] = s_axis_tdata_i[(NCOEF+i)*CW +: CW];
    if (size_q == SIZE_2X2) begin
      a_d[2] = '0;
      a_d[5] = '0;
      a_d[6] = '0;
      a_d[7] = '0;
      a_d[8] = CW'(1);
      b_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // Products for the 2x2 minors
  always_ff @(posedge clk_i) begin
    if (rdy[ST_PROD]) begin
      for (int i = 0; i < 2*NMIN; i++) prod_q[i] <= a_q[PROD_A[i]] * a_q[PROD_B[i]];
      col_s1_q <= '{a_q[0], a_q[3], a_q[6]};
      b_s1_q   <= b_q;
    end
  end

  // Minors
  always_ff @(posedge clk_i) begin
    if (rdy[ST_MINOR]) begin
      for (int k = 0; k < NMIN; k++) mn_q[k] <= MW'(prod_q[2*k]) - MW'(prod_q[2*k+1]);
      col_s2_q <= col_s1_q;
      b_s2_q   <= b_s1_q;
    end
  end

  // Cofactor terms: det, then numerators of x, y, z
  always_ff @(posedge clk_i) begin
    if (rdy[ST_TERM]) begin
      for (int r = 0; r < NRHS; r++) begin
        term_q[r]          <= DW'(mn_q[r])          * DW'(col_s2_q[r]);
        term_q[NRHS+r]     <= DW'(mn_q[r])          * DW'(b_s2_q[r]);
        term_q[2*NRHS+r]   <= DW'(mn_q[NRHS+r])     * DW'(b_s2_q[r]);
        term_q[3*NRHS+r]   <= DW'(mn_q[2*NRHS+r])   * DW'(b_s2_q[r]);
      end
    end
  end

  // Cofactor sums with their signs
  always_ff @(posedge clk_i) begin
    if (rdy[ST_SUM]) begin
      sum_q[0] <= term_q[0] - term_q[1] + term_q[2];
      sum_q[1] <= term_q[3] - term_q[4] + term_q[5];
      sum_q[2] <= term_q[7] - term_q[6] - term_q[8];
      sum_q[3] <= term_q[9] - term_q[10] + term_q[11];
    end
  end

  // Magnitudes, signs and overflow check for the dividers
  always_ff @(posedge clk_i) begin
    logic [DW-1:0]   det_abs;
    logic [DW-1:0]   num_abs;
    logic [MAGW-1:0] den;
    logic [MAGW-1:0] am;
    if (rdy[ST_PREP]) begin
      det_abs = sum_q[0][DW-1] ? DW'(-sum_q[0]) : DW'(sum_q[0]);
      den     = det_abs[MAGW-1:0];
      for (int k = 0; k < NRHS; k++) begin
        num_abs = sum_q[k+1][DW-1] ? DW'(-sum_q[k+1]) : DW'(sum_q[k+1]);
        am      = num_abs[MAGW-1:0];
        prep_q[k].rem <= MAGW'(am[MAGW-1:OF]);
        prep_q[k].den <= den;
        prep_q[k].quo <= '0;
        prep_q[k].low <= {am[OF-1:0], {(SW-OF){1'b0}}};
        prep_q[k].neg <= sum_q[k+1][DW-1] ^ sum_q[0][DW-1];
        prep_q[k].big <= MAGW'(am[MAGW-1:OF]) >= den;
      end
      det_p_q  <= sum_q[0];
      sing_p_q <= (sum_q[0] == '0);
    end
  end

  // Divider pipeline, two quotient bits per stage
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      for (int k = 0; k < NRHS; k++) begin
        div_src[j][k] = (j == 0) ? prep_q[k] : div_q[(j == 0) ? 0 : j-1][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (rdy[ST_DIV0+j]) begin
        for (int k = 0; k < NRHS; k++) div_q[j][k] <= div_step(div_step(div_src[j][k]));
        det_v_q[j]  <= (j == 0) ? det_p_q  : det_v_q[(j == 0) ? 0 : j-1];
        sing_v_q[j] <= (j == 0) ? sing_p_q : sing_v_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  // Saturation, sign and the singular case
  always_comb begin
    logic [SW-1:0] mag;
    for (int k = 0; k < NRHS; k++) begin
      if (div_q[DIV_STAGES-1][k].neg) begin
        sat_d[k] = div_q[DIV_STAGES-1][k].big || (div_q[DIV_STAGES-1][k].quo > SOL_MIN);
        mag      = sat_d[k] ? SOL_MIN : div_q[DIV_STAGES-1][k].quo;
        sol_d[k] = SW'(-mag);
      end else begin
        sat_d[k] = div_q[DIV_STAGES-1][k].big || div_q[DIV_STAGES-1][k].quo[SW-1];
        mag      = sat_d[k] ? SOL_MAX : div_q[DIV_STAGES-1][k].quo;
        sol_d[k] = mag;
      end
      if (sing_v_q[DIV_STAGES-1]) begin
        sat_d[k] = 1'b0;
        sol_d[k] = '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (rdy[NSTG]) begin
      sol_q    <= sol_d;
      sat_o_q  <= |sat_d;
      det_o_q  <= det_v_q[DIV_STAGES-1];
      sing_o_q <= sing_v_q[DIV_STAGES-1];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({sol_q[2], sol_q[1], sol_q[0], det_o_q});
  assign m_axis_tuser_o  = {sat_o_q, sing_o_q};

endmodule

@@ hdl/cls_core_checker.sv @@
`timescale 1ns / 1ps
`include "cramer_linear_solver_core_macros.svh"
module cls_core_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [cls_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input logic [cls_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o
);
  import cls_pkg::*;

  // A stalled result stays offered
  `CLS_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped under stall")

  // Singular flag matches a zero determinant; singular results are all zero
  `CLS_ASSERT(a_singular, m_axis_tvalid_o |-> ((m_axis_tdata_o[DW-1:0] == '0) == m_axis_tuser_o[USER_SING]) && (!m_axis_tuser_o[USER_SING] || (m_axis_tdata_o[SOLZ_LSB+SW-1:SOLX_LSB] == '0 && !m_axis_tuser_o[USER_SAT])), "singular result inconsistent")

  // A clipped result shows at least one rail value
  `CLS_ASSERT(a_sat_rail, m_axis_tvalid_o && m_axis_tuser_o[USER_SAT] |-> m_axis_tdata_o[SOLX_LSB +: SW] == SOL_MAX || m_axis_tdata_o[SOLX_LSB +: SW] == SOL_MIN || m_axis_tdata_o[SOLY_LSB +: SW] == SOL_MAX || m_axis_tdata_o[SOLY_LSB +: SW] == SOL_MIN || m_axis_tdata_o[SOLZ_LSB +: SW] == SOL_MAX || m_axis_tdata_o[SOLZ_LSB +: SW] == SOL_MIN, "saturated without rail value")

  // Input backpressure only when the output holds a result
  `CLS_ASSERT_ALWAYS(a_bp_cause, !s_axis_tready_o |-> m_axis_tvalid_o, "input stalled with empty output")

endmodule

bind cramer_linear_solver_core cls_core_checker u_cls_core_checker (.*);
